### rtl/gmpb_pkg.sv
package gmpb_pkg;

  localparam int DEF_GRID_ROWS = 256;
  localparam int DEF_GRID_COLS = 256;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CELL_RECIP = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS_USED  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_USED  = 3'd4;

  localparam logic [1:0] CMD_INSERT     = 2'd0;
  localparam logic [1:0] CMD_READ       = 2'd1;
  localparam logic [1:0] CMD_READ_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [7:0]         cell_row;
    logic [7:0]         cell_col;
  } item_t;

  typedef struct packed {
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] cell_z;
    logic               cell_valid;
    logic               updated;
  } result_t;

  // one memory word per grid cell
  typedef struct packed {
    logic               valid;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cell_word_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

### rtl/grid_min_point_binning.sv
// Minimum-z point binning into a GRID_ROWS x GRID_COLS grid. A command is
// taken when start is high and busy is low; its one result appears on result
// with done high for exactly one cycle and cannot be held off, so the
// receiver must take it then. An insert steps through difference, column
// multiply, row multiply and clamp, using one shared 32x32 multiplier for
// the column and then the row, then a read-modify-write of the single-port
// cell memory; a read or read-and-clear goes straight to the memory access.
// After reset the block sweeps the cell memory to clear all valid marks, one
// cell a cycle, over all GRID_ROWS*GRID_COLS cells (65536 by default); busy
// stays high until the sweep is over. Register writes are taken at any time.
module grid_min_point_binning #(
  parameter int GRID_ROWS = gmpb_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = gmpb_pkg::DEF_GRID_COLS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  gmpb_pkg::item_t                  item,
  output logic                             done,
  output gmpb_pkg::result_t                result,
  input  logic                             cfg_we,
  input  logic [gmpb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gmpb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CELLS  = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIFF  = 3'd2;
  localparam logic [2:0] ST_MULX  = 3'd3;
  localparam logic [2:0] ST_MULY  = 3'd4;
  localparam logic [2:0] ST_CLAMP = 3'd5;
  localparam logic [2:0] ST_READ  = 3'd6;
  localparam logic [2:0] ST_WRITE = 3'd7;

  logic signed [31:0] origin_x;
  logic signed [31:0] top_y;
  logic [31:0]        cell_recip;
  logic [8:0]         cols_used;
  logic [8:0]         rows_used;

  logic [2:0]         state;
  gmpb_pkg::item_t    cur;
  logic [31:0]        mag_x;
  logic [31:0]        mag_y;
  logic               pos_x;
  logic               pos_y;
  logic [63:0]        prod;
  logic [ROW_W-1:0]   row_idx;
  logic [COL_W-1:0]   col_idx;
  logic               in_grid;

  logic [32:0]        diff_x;
  logic [32:0]        diff_y;
  logic [31:0]        lim_c;
  logic [31:0]        lim_r;
  logic [31:0]        mul_a;
  logic [ADDR_W-1:0]  cell_addr;
  logic [15:0]        row_wide;
  logic [15:0]        col_wide;
  logic               is_insert;
  logic               take;

  gmpb_pkg::mem_ctl_t   mem_ctl;
  gmpb_pkg::cell_word_t mem_wdata;
  gmpb_pkg::cell_word_t mem_rdata;
  logic                 mem_ready;

  function automatic logic [31:0] eff_limit(input logic [8:0] used, input int phys);
    logic [31:0] u;
    u = 32'(used);
    if (u == 32'd0) begin
      return 32'd1;
    end
    if (u > 32'(phys)) begin
      return 32'(phys);
    end
    return u;
  endfunction

  // floor of the product over 2^24, clamped into [0, limit-1]
  function automatic logic [31:0] clamp_idx(input logic [39:0] q, input logic pos,
                                            input logic [31:0] limit);
    if (!pos) begin
      return 32'd0;
    end
    if (q >= 40'(limit)) begin
      return limit - 32'd1;
    end
    return q[31:0];
  endfunction

  assign busy      = (state != ST_IDLE);
  assign is_insert = (cur.command == gmpb_pkg::CMD_INSERT);

  assign diff_x = {cur.point_x[31], cur.point_x} - {origin_x[31], origin_x};
  assign diff_y = {top_y[31], top_y} - {cur.point_y[31], cur.point_y};
  assign lim_c  = eff_limit(cols_used, GRID_COLS);
  assign lim_r  = eff_limit(rows_used, GRID_ROWS);
  assign mul_a  = (state == ST_MULX) ? mag_x : mag_y;

  assign cell_addr = ADDR_W'(32'(row_idx) * GRID_COLS + 32'(col_idx));
  assign row_wide  = 16'(row_idx);
  assign col_wide  = 16'(col_idx);

  assign take = !mem_rdata.valid || (cur.point_z < mem_rdata.z);

  always_comb begin
    mem_ctl   = '0;
    mem_wdata = '0;
    if (state == ST_READ) begin
      mem_ctl.rd = 1'b1;
    end
    if (state == ST_WRITE) begin
      if (is_insert) begin
        mem_ctl.wr      = take;
        mem_wdata.valid = 1'b1;
        mem_wdata.x     = cur.point_x;
        mem_wdata.y     = cur.point_y;
        mem_wdata.z     = cur.point_z;
      end else if (cur.command == gmpb_pkg::CMD_READ_CLEAR && in_grid) begin
        mem_ctl.wr      = 1'b1;
        mem_wdata       = mem_rdata;
        mem_wdata.valid = 1'b0;
      end
    end
  end

  gmpb_cell_store #(
    .CELLS  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mem_ctl),
    .addr  (cell_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata),
    .ready (mem_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      top_y      <= '0;
      cell_recip <= 32'd65536;
      cols_used  <= 9'd256;
      rows_used  <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        gmpb_pkg::REG_ORIGIN_X:   origin_x   <= cfg_data;
        gmpb_pkg::REG_TOP_Y:      top_y      <= cfg_data;
        gmpb_pkg::REG_CELL_RECIP: cell_recip <= cfg_data;
        gmpb_pkg::REG_COLS_USED:  cols_used  <= cfg_data[8:0];
        gmpb_pkg::REG_ROWS_USED:  rows_used  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          if (mem_ready) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state <= (item.command == gmpb_pkg::CMD_INSERT) ? ST_DIFF : ST_READ;
          end
        end
        ST_DIFF:  state <= ST_MULX;
        ST_MULX:  state <= ST_MULY;
        ST_MULY:  state <= ST_CLAMP;
        ST_CLAMP: state <= ST_READ;
        ST_READ:  state <= ST_WRITE;
        ST_WRITE: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          cur     <= item;
          row_idx <= ROW_W'(item.cell_row);
          col_idx <= COL_W'(item.cell_col);
          in_grid <= (32'(item.cell_row) < GRID_ROWS) && (32'(item.cell_col) < GRID_COLS);
        end
      end
      ST_DIFF: begin
        mag_x <= diff_x[31:0];
        mag_y <= diff_y[31:0];
        pos_x <= !diff_x[32] && (diff_x != 33'd0);
        pos_y <= !diff_y[32] && (diff_y != 33'd0);
      end
      ST_MULX: begin
        prod <= 64'(mul_a) * 64'(cell_recip);
      end
      ST_MULY: begin
        prod    <= 64'(mul_a) * 64'(cell_recip);
        col_idx <= COL_W'(clamp_idx(prod[63:24], pos_x, lim_c));
      end
      ST_CLAMP: begin
        row_idx <= ROW_W'(clamp_idx(prod[63:24], pos_y, lim_r));
        in_grid <= 1'b1;
      end
      ST_WRITE: begin
        if (is_insert) begin
          result.row        <= row_wide[7:0];
          result.col        <= col_wide[7:0];
          result.cell_valid <= 1'b1;
          result.updated    <= take;
          if (take) begin
            result.cell_x <= cur.point_x;
            result.cell_y <= cur.point_y;
            result.cell_z <= cur.point_z;
          end else begin
            result.cell_x <= mem_rdata.x;
            result.cell_y <= mem_rdata.y;
            result.cell_z <= mem_rdata.z;
          end
        end else begin
          result.row     <= cur.cell_row;
          result.col     <= cur.cell_col;
          result.updated <= 1'b0;
          if (in_grid && mem_rdata.valid) begin
            result.cell_valid <= 1'b1;
            result.cell_x     <= mem_rdata.x;
            result.cell_y     <= mem_rdata.y;
            result.cell_z     <= mem_rdata.z;
          end else begin
            result.cell_valid <= 1'b0;
            result.cell_x     <= '0;
            result.cell_y     <= '0;
            result.cell_z     <= '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/gmpb_cell_store.sv
module gmpb_cell_store #(
  parameter int CELLS  = gmpb_pkg::DEF_GRID_ROWS * gmpb_pkg::DEF_GRID_COLS,
  parameter int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gmpb_pkg::mem_ctl_t   ctl,
  input  logic [ADDR_W-1:0]    addr,
  input  gmpb_pkg::cell_word_t wdata,
  output gmpb_pkg::cell_word_t rdata,
  output logic                 ready
);

  gmpb_pkg::cell_word_t mem [CELLS];

  logic [ADDR_W-1:0] clr_cnt;
  logic              clearing;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  gmpb_pkg::cell_word_t wword;

  assign ready = !clearing;
  assign we    = clearing || ctl.wr;
  assign waddr = clearing ? clr_cnt : addr;
  assign wword = clearing ? '0 : wdata;

  // sweep every entry once after reset to drop all valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      if (clr_cnt == ADDR_W'(CELLS - 1)) begin
        clearing <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wword;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

### bench/grid_min_point_binning_tb.sv
module grid_min_point_binning_tb;
  import gmpb_pkg::*;

  localparam logic [1:0] CMD_READ_ALT = 2'd3;
  localparam int WATCHDOG_LIMIT = 200000;

  class min_cell_tracker;
    bit signed [31:0] x_mem [65536];
    bit signed [31:0] y_mem [65536];
    bit signed [31:0] z_mem [65536];
    bit occupied [65536];
    bit written [65536];
    int unsigned touched[$];
    result_t due_cells[$];
    int errors;

    bit signed [31:0] org_x;
    bit signed [31:0] top_edge;
    bit [31:0] cell_recip;
    bit [8:0] cols_cfg;
    bit [8:0] rows_cfg;

    function new();
      org_x = 0;
      top_edge = 0;
      cell_recip = 32'd65536;
      cols_cfg = 9'd256;
      rows_cfg = 9'd256;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] d);
      case (idx)
        REG_ORIGIN_X: org_x = d;
        REG_TOP_Y: top_edge = d;
        REG_CELL_RECIP: cell_recip = d;
        REG_COLS_USED: cols_cfg = d[8:0];
        REG_ROWS_USED: rows_cfg = d[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned used_extent(bit [8:0] used, int unsigned phys);
      if (used == 0) return 1;
      if (used > phys) return phys;
      return 32'(used);
    endfunction

    // floor(diff * recip / 2^24), clamped into the grid in use
    function logic [7:0] to_cell_index(longint diff, int unsigned lim);
      longint unsigned prod;
      if (diff <= 0) return 8'd0;
      prod = diff;
      prod = prod * cell_recip;
      prod = prod >> 24;
      if (prod >= lim) return 8'(lim - 1);
      return prod[7:0];
    endfunction

    function void take_command(item_t it);
      result_t r;
      longint dx;
      longint dy;
      int unsigned idx;
      r = '0;
      if (it.command == CMD_INSERT) begin
        dx = longint'(it.point_x) - longint'(org_x);
        dy = longint'(top_edge) - longint'(it.point_y);
        r.col = to_cell_index(dx, used_extent(cols_cfg, DEF_GRID_COLS));
        r.row = to_cell_index(dy, used_extent(rows_cfg, DEF_GRID_ROWS));
        idx = 32'({r.row, r.col});
        if (!occupied[idx] || it.point_z < z_mem[idx]) begin
          x_mem[idx] = it.point_x;
          y_mem[idx] = it.point_y;
          z_mem[idx] = it.point_z;
          occupied[idx] = 1'b1;
          r.updated = 1'b1;
          if (!written[idx]) begin
            written[idx] = 1'b1;
            touched = {touched, idx};
          end
        end
        r.cell_x = x_mem[idx];
        r.cell_y = y_mem[idx];
        r.cell_z = z_mem[idx];
        r.cell_valid = 1'b1;
      end else begin
        r.row = it.cell_row;
        r.col = it.cell_col;
        idx = 32'({r.row, r.col});
        if (occupied[idx]) begin
          r.cell_x = x_mem[idx];
          r.cell_y = y_mem[idx];
          r.cell_z = z_mem[idx];
          r.cell_valid = 1'b1;
          if (it.command == CMD_READ_CLEAR) occupied[idx] = 1'b0;
        end
      end
      due_cells = {due_cells, r};
    endfunction

    function void cmp(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_cell(result_t got);
      result_t want;
      if (due_cells.size() == 0) begin
        $display("%0t: unexpected result row %h col %h", $time, got.row, got.col);
        errors++;
        return;
      end
      want = due_cells.pop_front();
      cmp("row", 32'(want.row), 32'(got.row));
      cmp("col", 32'(want.col), 32'(got.col));
      cmp("cell_x", want.cell_x, got.cell_x);
      cmp("cell_y", want.cell_y, got.cell_y);
      cmp("cell_z", want.cell_z, got.cell_z);
      cmp("cell_valid", 32'(want.cell_valid), 32'(got.cell_valid));
      cmp("updated", 32'(want.updated), 32'(got.updated));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  item_t item;
  logic done;
  result_t result;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  min_cell_tracker tracker;
  int idle_run;

  grid_min_point_binning u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_run <= 0;
    end else begin
      if (start && !busy) tracker.take_command(item);
      if (done) tracker.check_cell(result);
      if (cfg_we) tracker.set_reg(cfg_index, cfg_data);
      if ((start && !busy) || done) begin
        idle_run <= 0;
      end else if (idle_run >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  task cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [31:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
  endtask

  task set_config(logic [31:0] ox, logic [31:0] ty, logic [31:0] rc,
                  logic [31:0] cu, logic [31:0] ru);
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_TOP_Y, ty);
    cfg_write(REG_CELL_RECIP, rc);
    cfg_write(REG_COLS_USED, cu);
    cfg_write(REG_ROWS_USED, ru);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // gap is counted in idle cycles before this transfer
  task send_item(item_t it, int gap);
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task drain();
    @(negedge clk) start <= 1'b0;
    @(posedge clk);
    while (tracker.due_cells.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic item_t mk_insert(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    item_t it;
    it.command = CMD_INSERT;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    it.cell_row = 8'($urandom);
    it.cell_col = 8'($urandom);
    return it;
  endfunction

  function automatic item_t mk_read(logic [1:0] cmd, logic [7:0] r, logic [7:0] c);
    item_t it;
    it.command = cmd;
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.point_z = $urandom;
    it.cell_row = r;
    it.cell_col = c;
    return it;
  endfunction

  // coordinate mostly spread over the grid in use plus about one cell either side, else random
  function automatic logic [31:0] aim(logic [31:0] base, bit [8:0] used, bit down);
    longint unsigned w;
    longint unsigned span;
    longint unsigned off;
    if ($urandom_range(0, 4) == 0) return $urandom;
    if (tracker.cell_recip == 0) w = 64'h1_0000_0000;
    else w = (64'd1 << 24) / tracker.cell_recip;
    if (w == 0) w = 1;
    span = w * tracker.used_extent(used, 256) + 2 * w;
    off = {$urandom, $urandom} % (span + 1);
    off = off - w;
    return down ? base - off[31:0] : base + off[31:0];
  endfunction

  function automatic logic [31:0] pick_z();
    int p;
    p = $urandom_range(0, 9);
    if (p < 7) return $urandom_range(0, 4000) - 2000;
    return $urandom;
  endfunction

  function automatic item_t random_item();
    int unsigned idx;
    int p;
    p = $urandom_range(0, 99);
    if (p < 25 && tracker.touched.size() != 0) begin
      idx = tracker.touched[$urandom_range(0, tracker.touched.size() - 1)];
      if (p < 11) return mk_read(CMD_READ, idx[15:8], idx[7:0]);
      if (p < 22) return mk_read(CMD_READ_CLEAR, idx[15:8], idx[7:0]);
      return mk_read(CMD_READ_ALT, idx[15:8], idx[7:0]);
    end
    return mk_insert(aim(tracker.org_x, tracker.cols_cfg, 1'b0),
                     aim(tracker.top_edge, tracker.rows_cfg, 1'b1), pick_z());
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [31:0] pick_edge();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 1 << 21) - (1 << 20);
  endfunction

  function automatic logic [31:0] pick_recip();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'd0;
      2: return 32'hffff_ffff;
      3: return 32'd1;
      default: return $urandom_range(1 << 13, 1 << 19);
    endcase
  endfunction

  // junk above bit 8 must be ignored
  function automatic logic [31:0] pick_used();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 256;
      2: v = $urandom_range(257, 511);
      3: v = 1;
      default: v = $urandom_range(2, 12);
    endcase
    return ($urandom & 32'hffff_fe00) | v;
  endfunction

  initial begin
    int p;
    int n;
    bit quiet;
    tracker = new();
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    drain();

    // unit cells, 8x8 grid, top edge at y = 8.0
    set_config(32'd0, 32'd2048, 32'd65536, 32'd8, 32'd8);
    send_item(mk_insert(32'd128, 32'd1920, 32'd100), 0);
    send_item(mk_insert(32'd200, 32'd2000, 32'd200), 0);
    send_item(mk_insert(32'd100, 32'd1900, 32'd100), 0);
    send_item(mk_insert(32'd50, 32'd1950, -32'sd5), 0);
    send_item(mk_insert(32'h8000_0000, 32'h7fff_ffff, 32'd7), 0);
    send_item(mk_insert(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff), 0);
    send_item(mk_insert(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000), 0);
    send_item(mk_insert(32'd778, 32'd767, 32'd0), 0);
    send_item(mk_insert(32'd1023, 32'd513, 32'd1), 0);
    send_item(mk_read(CMD_READ, 8'd0, 8'd0), 0);
    send_item(mk_read(CMD_READ_ALT, 8'd5, 8'd3), 0);
    send_item(mk_read(CMD_READ_CLEAR, 8'd7, 8'd7), 0);
    send_item(mk_read(CMD_READ, 8'd7, 8'd7), 0);
    send_item(mk_insert(32'h7fff_ffff, 32'h8000_0000, 32'd1000), 0);
    send_item(mk_read(CMD_READ_CLEAR, 8'd0, 8'd0), 0);
    send_item(mk_read(CMD_READ_CLEAR, 8'd0, 8'd0), 0);
    drain();

    // zero reciprocal puts everything in cell 0; zero columns act as one
    set_config(32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'hffff_fe00, 32'd300);
    send_item(mk_insert($urandom, $urandom, 32'd5), 0);
    send_item(mk_insert(32'h8000_0000, 32'h7fff_ffff, 32'd9), 0);
    drain();

    // tiny cells: small offsets already clamp to the last column
    set_config(32'd0, 32'd0, 32'hffff_ffff, 32'd300, 32'd0);
    send_item(mk_insert(32'h100, -32'sh100, 32'd3), 0);
    send_item(mk_insert(32'd1, -32'sd1, 32'd2), 0);
    send_item(mk_read(CMD_READ, 8'd0, 8'd255), 0);
    drain();

    for (p = 0; p < 12; p++) begin
      case (p)
        0: set_config(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd511, 32'd0);
        1: set_config(32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'd1, 32'd256);
        2: set_config(32'd0, 32'd0, 32'd65536, 32'd256, 32'd256);
        default: set_config(pick_edge(), pick_edge(), pick_recip(), pick_used(), pick_used());
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 133; n++) begin
        send_item(random_item(), quiet ? 0 : pick_gap());
        if ($urandom_range(0, 199) == 0) drain();
      end
      drain();
    end

    if (tracker.errors == 0 && tracker.due_cells.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/gmpb_pkg.sv
rtl/gmpb_cell_store.sv
rtl/grid_min_point_binning.sv
bench/grid_min_point_binning_tb.sv
